// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/e2q_pkg.sv -----
package e2q_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int OUT_W        = FRAC_BITS + 2;
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // Rotator x and y carry 40 fraction bits plus headroom; z holds the half angle
  // in units where a full turn is 2^33, plus the largest partial atan sum.
  localparam int XY_W   = 43;
  localparam int Z_W    = 34;
  localparam int Z_SHIFT = 32 - ANGLE_BITS;

  // Sine and cosine with 30 fraction bits, and the products built from them.
  localparam int TRIG_W = 32;
  localparam int PROD_W = 2 * TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [XY_W-1:0] GAIN_INV = XY_W'(64'sd667681663043);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  // atan(2^-i) in units where a full turn is 2^32.
  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      5'd25:   v = 30'd20;
      5'd26:   v = 30'd10;
      5'd27:   v = 30'd5;
      5'd28:   v = 30'd3;
      5'd29:   v = 30'd1;
      5'd30:   v = 30'd1;
      default: v = 30'd0;
    endcase
    return signed'({{(Z_W-30){1'b0}}, v});
  endfunction

endpackage

// ----- hw/rtl/e2q_cordic_cell.sv -----
module e2q_cordic_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [e2q_pkg::STEP_W-1:0]    step,
  input  logic                          vld_in,
  input  e2q_pkg::rot_t [2:0]           rot_in,
  output logic                          vld_r,
  output e2q_pkg::rot_t [2:0]           rot_r
);
  import e2q_pkg::*;

  rot_t [2:0] rot_nxt;

  // One rotation step for each of the three angles.
  always_comb begin
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  dz;
    for (int a = 0; a < 3; a++) begin
      x_in = rot_in[a].x;
      y_in = rot_in[a].y;
      z_in = rot_in[a].z;
      dx   = y_in >>> step;
      dy   = x_in >>> step;
      dz   = atan_step(step) <<< 1;
      if (!z_in[Z_W-1]) begin
        rot_nxt[a].x = x_in - dx;
        rot_nxt[a].y = y_in + dy;
        rot_nxt[a].z = z_in - dz;
      end else begin
        rot_nxt[a].x = x_in + dx;
        rot_nxt[a].y = y_in - dy;
        rot_nxt[a].z = z_in + dz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

endmodule

// ----- hw/rtl/euler_to_quaternion.sv -----
// An accepted item reaches the out_ port through 32 CORDIC cells, then trig
// rounding, pair-product, triple-product and output stages, all advancing
// together; one item per cycle is taken whenever in_stall is low.
// Reset (rst_n low, synchronous) empties the pipeline and the output register;
// no other state exists.
module euler_to_quaternion (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] in_yaw_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [e2q_pkg::OUT_W-1:0]    out_quat_scalar,
  output logic signed [e2q_pkg::OUT_W-1:0]    out_quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0]    out_quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0]    out_quat_z
);
  import e2q_pkg::*;

  localparam logic signed [XY_W-1:0]   TRIG_HALF = XY_W'(512);
  localparam logic signed [PROD_W-1:0] PAIR_HALF = PROD_W'(64'sd536870912);
  localparam logic signed [SUM_W-1:0]  FIN_HALF  = SUM_W'(1) << (59 - FRAC_BITS);
  localparam logic signed [SUM_W-1:0]  FIN_ONE   = SUM_W'(1) << FRAC_BITS;

  // The whole pipeline moves as one. It freezes only when the output register
  // holds an item that is stalled and the last stage also has an item ready
  // for it; a bubble in the last stage lets new items keep coming in.
  logic adv;
  logic out_load;
  logic out_valid_r;
  logic trip_vld_r;

  assign adv      = !(out_valid_r && out_stall && trip_vld_r);
  assign in_stall = !adv;
  assign out_load = !out_valid_r || !out_stall;

  // Each angle is sign-extended and scaled so that it reads as the half angle
  // in units where a full turn is 2^33; the rotators start at the gain
  // compensation on x and zero on y.
  rot_t [2:0] chain_rot [CORDIC_STEPS+1];
  logic       chain_vld [CORDIC_STEPS+1];

  assign chain_vld[0]    = in_valid;
  assign chain_rot[0][0] = {GAIN_INV, {XY_W{1'b0}}, Z_W'(in_roll_angle) <<< Z_SHIFT};
  assign chain_rot[0][1] = {GAIN_INV, {XY_W{1'b0}}, Z_W'(in_pitch_angle) <<< Z_SHIFT};
  assign chain_rot[0][2] = {GAIN_INV, {XY_W{1'b0}}, Z_W'(in_yaw_angle) <<< Z_SHIFT};

  // The CORDIC chain: cell g performs rotation step g for all three angles.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .step   (STEP_W'(g)),
      .vld_in (chain_vld[g]),
      .rot_in (chain_rot[g]),
      .vld_r  (chain_vld[g+1]),
      .rot_r  (chain_rot[g+1])
    );
  end

  // Sine and cosine of each half angle, rounded to 30 fraction bits.
  // Index 0 is roll, 1 is pitch, 2 is yaw.
  logic                     trig_vld_r;
  logic signed [TRIG_W-1:0] sin_r [3];
  logic signed [TRIG_W-1:0] cos_r [3];
  logic signed [TRIG_W-1:0] sin_nxt [3];
  logic signed [TRIG_W-1:0] cos_nxt [3];

  always_comb begin
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] xs;
    for (int a = 0; a < 3; a++) begin
      ys = (chain_rot[CORDIC_STEPS][a].y + TRIG_HALF) >>> 10;
      xs = (chain_rot[CORDIC_STEPS][a].x + TRIG_HALF) >>> 10;
      sin_nxt[a] = ys[TRIG_W-1:0];
      cos_nxt[a] = xs[TRIG_W-1:0];
    end
  end

  // Roll-pitch pair products: cr*cp, sr*sp, sr*cp, cr*sp. The yaw sine and
  // cosine ride along for the next stage.
  logic                     pair_vld_r;
  logic signed [PROD_W-1:0] pair_r [4];
  logic signed [TRIG_W-1:0] sy_r;
  logic signed [TRIG_W-1:0] cy_r;

  // Triple products, each a rounded pair product times the yaw term.
  logic signed [PROD_W-1:0] trip_r [8];
  logic signed [PROD_W-1:0] trip_nxt [8];
  logic signed [TRIG_W-1:0] pair_rnd [4];

  always_comb begin
    logic signed [PROD_W-1:0] t;
    for (int k = 0; k < 4; k++) begin
      t = (pair_r[k] + PAIR_HALF) >>> 30;
      pair_rnd[k] = t[TRIG_W-1:0];
    end
    trip_nxt[0] = pair_rnd[0] * cy_r;
    trip_nxt[1] = pair_rnd[1] * sy_r;
    trip_nxt[2] = pair_rnd[2] * cy_r;
    trip_nxt[3] = pair_rnd[3] * sy_r;
    trip_nxt[4] = pair_rnd[3] * cy_r;
    trip_nxt[5] = pair_rnd[2] * sy_r;
    trip_nxt[6] = pair_rnd[0] * sy_r;
    trip_nxt[7] = pair_rnd[1] * cy_r;
  end

  // Final sums and differences, rounded to FRAC_BITS and clamped to +-1.0.
  function automatic logic signed [OUT_W-1:0] finish(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b,
    input logic                     sub
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] v;
    s = sub ? (SUM_W'(a) - SUM_W'(b)) : (SUM_W'(a) + SUM_W'(b));
    v = (s + FIN_HALF) >>> (60 - FRAC_BITS);
    if (v > FIN_ONE) begin
      v = FIN_ONE;
    end else if (v < -FIN_ONE) begin
      v = -FIN_ONE;
    end
    return v[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] w_nxt;
  logic signed [OUT_W-1:0] x_nxt;
  logic signed [OUT_W-1:0] y_nxt;
  logic signed [OUT_W-1:0] z_nxt;

  assign w_nxt = finish(trip_r[0], trip_r[1], 1'b0);
  assign x_nxt = finish(trip_r[2], trip_r[3], 1'b1);
  assign y_nxt = finish(trip_r[4], trip_r[5], 1'b0);
  assign z_nxt = finish(trip_r[6], trip_r[7], 1'b1);

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_vld_r <= 1'b0;
      pair_vld_r <= 1'b0;
      trip_vld_r <= 1'b0;
    end else if (adv) begin
      trig_vld_r <= chain_vld[CORDIC_STEPS];
      pair_vld_r <= trig_vld_r;
      trip_vld_r <= pair_vld_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      sin_r     <= sin_nxt;
      cos_r     <= cos_nxt;
      pair_r[0] <= cos_r[0] * cos_r[1];
      pair_r[1] <= sin_r[0] * sin_r[1];
      pair_r[2] <= sin_r[0] * cos_r[1];
      pair_r[3] <= cos_r[0] * sin_r[1];
      sy_r      <= sin_r[2];
      cy_r      <= cos_r[2];
      trip_r    <= trip_nxt;
    end
  end

  // Output register: it takes the last stage's item whenever it is empty or
  // its own item is being taken in the same cycle.
  logic signed [OUT_W-1:0] quat_w_r;
  logic signed [OUT_W-1:0] quat_x_r;
  logic signed [OUT_W-1:0] quat_y_r;
  logic signed [OUT_W-1:0] quat_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= trip_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && trip_vld_r) begin
      quat_w_r <= w_nxt;
      quat_x_r <= x_nxt;
      quat_y_r <= y_nxt;
      quat_z_r <= z_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quat_scalar = quat_w_r;
  assign out_quat_x      = quat_x_r;
  assign out_quat_y      = quat_y_r;
  assign out_quat_z      = quat_z_r;

endmodule

// ----- hw/rtl/e2q_checker.sv -----
`include "assert_macros.svh"

module e2q_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [e2q_pkg::OUT_W-1:0] out_quat_scalar,
  input logic signed [e2q_pkg::OUT_W-1:0] out_quat_x,
  input logic signed [e2q_pkg::OUT_W-1:0] out_quat_y,
  input logic signed [e2q_pkg::OUT_W-1:0] out_quat_z
);
  import e2q_pkg::*;

  localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_BITS;

  logic sat_ok;

  assign sat_ok = out_quat_scalar <= ONE && out_quat_scalar >= -ONE &&
                  out_quat_x <= ONE && out_quat_x >= -ONE &&
                  out_quat_y <= ONE && out_quat_y >= -ONE &&
                  out_quat_z <= ONE && out_quat_z >= -ONE;

  // A result stays offered while it is stalled.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid)

  // The input side is held back only by a stalled result at the output.
  `ASSERT_CLK(a_stall_cause, in_stall |-> out_valid && out_stall)

  // Every delivered component is clamped to plus or minus one.
  `ASSERT_CLK(a_sat_range, out_valid |-> sat_ok)

  // Reset empties the block, so no result follows a reset cycle.
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);
